[hdl/bat_pkg.sv]
// Shared operation codes, status codes and cell control type of the breakpoint table.
package bat_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;

   // Operation broadcast to every cell in the row.
   typedef struct packed {
      logic              exec;
      logic              do_add;
      logic              do_remove;
      logic [ADDR_W-1:0] addr;
   } cell_ctrl_type;

endpackage

[hdl/bat_cell.sv]
// One table cell: holds one entry, compares it, and shifts from its upper neighbor.
module bat_cell #(
   parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEFAULT,
   parameter int CELL_INDEX  = 0,
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                        clock,
   input  bat_pkg::cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]            count,
   input  logic                        match_in,
   input  logic [bat_pkg::ADDR_W-1:0]  next_entry,
   output logic                        match_out,
   output logic [bat_pkg::ADDR_W-1:0]  entry
);

   logic [bat_pkg::ADDR_W-1:0] entry_ff, entry_in;
   logic valid;
   logic shift_ok;

   assign valid     = CNT_W'(CELL_INDEX) < count;
   assign shift_ok  = CNT_W'(CELL_INDEX + 1) < count;
   // The match token ripples upward: it is set from the first matching cell on.
   assign match_out = match_in | (valid && (entry_ff == ctrl.addr));
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.exec && ctrl.do_add && (count == CNT_W'(CELL_INDEX))) begin
         entry_in = ctrl.addr;
      end else if (ctrl.exec && ctrl.do_remove && match_out && shift_ok) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[hdl/breakpoint_address_table_core.sv]
// Top level of the breakpoint address table: request capture, cell row and result register.
//
// The block keeps an ordered list of up to TABLE_DEPTH 16-bit breakpoint addresses in a
// row of cells, one entry per cell. A request beat is captured in the request registers
// and executed once the result register is free, when every cell compares its entry with
// the address at once and a match token ripples up the row to find the first hit. A lookup
// only reports; an add writes the cell at the current count; a remove makes every cell
// from the first hit upward take the entry of its upper neighbor, which closes the gap and
// keeps the order. The result beat is registered when the item executes and offered on the
// rsp_ channel. The block holds one item at a time, so it takes no new request beat until
// the captured one has executed; a result beat that is not taken holds the next item in
// the execute stage until the result register frees. Operation code 3 behaves as a lookup.
// After reset the table is empty and entries are valid only below the count, so no
// clearing pass is needed. With TABLE_DEPTH above 31 the reported entry count is the
// count masked to five bits.
module breakpoint_address_table_core #(
   parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bat_pkg::FUNC_W-1:0]    req_func,
   input  logic [bat_pkg::ADDR_W-1:0]    req_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [bat_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bat_pkg::COUNT_W-1:0]   rsp_entry_count
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Captured request, waiting for the execute cycle.
   logic                       busy_ff;
   logic [bat_pkg::FUNC_W-1:0] func_ff;
   logic [bat_pkg::ADDR_W-1:0] addr_ff;

   logic [CNT_W-1:0] count_ff, count_in;

   // Result register.
   logic                         rsp_valid_ff;
   logic                         hit_ff;
   logic [bat_pkg::STATUS_W-1:0] status_ff, status_in;

   logic exec;
   logic found;
   logic full;
   bat_pkg::cell_ctrl_type ctrl;

   logic [TABLE_DEPTH:0]        match_chain;
   logic [bat_pkg::ADDR_W-1:0]  entry_bus [TABLE_DEPTH];

   assign req_ready = !busy_ff;
   // The captured item executes once the result register is free or being emptied.
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign full      = count_ff == CNT_W'(TABLE_DEPTH);
   assign found     = match_chain[TABLE_DEPTH];

   assign ctrl.exec      = exec;
   assign ctrl.do_add    = (func_ff == bat_pkg::FUNC_ADD);
   assign ctrl.do_remove = (func_ff == bat_pkg::FUNC_REMOVE);
   assign ctrl.addr      = addr_ff;

   assign match_chain[0] = 1'b0;

   // The row of cells. Each cell passes the match token up and its entry down.
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      logic [bat_pkg::ADDR_W-1:0] next_entry;
      if (k == TABLE_DEPTH - 1) begin : g_top
         assign next_entry = entry_bus[k];
      end else begin : g_mid
         assign next_entry = entry_bus[k + 1];
      end
      bat_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_INDEX  (k),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .match_in   (match_chain[k]),
         .next_entry (next_entry),
         .match_out  (match_chain[k + 1]),
         .entry      (entry_bus[k])
      );
   end

   // Count update and status for the item in the execute cycle.
   always_comb begin
      count_in  = count_ff;
      status_in = bat_pkg::STATUS_OK;
      case (func_ff)
         bat_pkg::FUNC_ADD: begin
            if (full) begin
               status_in = bat_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         bat_pkg::FUNC_REMOVE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = bat_pkg::STATUS_NOTFOUND;
            end
         end
         default: begin
            count_in  = count_ff;
            status_in = bat_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            busy_ff <= 1'b1;
         end else if (exec) begin
            busy_ff <= 1'b0;
         end
         if (exec) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         addr_ff <= req_addr;
      end
      if (exec) begin
         hit_ff    <= found;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = bat_pkg::COUNT_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      exec && ctrl.do_add && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("add did not grow the table");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      exec && ctrl.do_remove && found |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the table");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == bat_pkg::STATUS_FULL |-> full)
      else $error("full status reported on a table that is not full");

   a_notfound_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == bat_pkg::STATUS_NOTFOUND |-> !hit_ff)
      else $error("not-found status reported together with a hit");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the breakpoint address table core.
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_DEPTH  = bat_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 100_000;
   localparam int REPORT_LIMIT = 10;

   // The fourth operation code has no function of its own; the block treats it as a lookup.
   localparam logic [bat_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   // One response beat, field by field.
   typedef struct packed {
      logic                         hit;
      logic [bat_pkg::STATUS_W-1:0] status;
      logic [bat_pkg::COUNT_W-1:0]  entry_count;
   } bat_result_type;

   // One row of the directed sequence. When typed is set, the response is checked against
   // the value written in the row; otherwise the table model supplies it.
   typedef struct packed {
      logic [bat_pkg::FUNC_W-1:0] func;
      logic [bat_pkg::ADDR_W-1:0] addr;
      logic                       typed;
      bat_result_type             want;
   } directed_row_type;

   localparam bat_result_type NO_RESULT = '0;

   // The directed part starts from an empty table: a lookup and a remove on the empty table,
   // the spare operation code, the address extremes, a duplicate add, filling the table to
   // its last entry, an add that the full table refuses (it still reports the hit), and
   // removes that must take only the first of two equal entries.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{bat_pkg::FUNC_LOOKUP, 16'h0000, 1'b1, '{1'b0, bat_pkg::STATUS_OK,       5'd0}},
      '{bat_pkg::FUNC_REMOVE, 16'hFFFF, 1'b1, '{1'b0, bat_pkg::STATUS_NOTFOUND, 5'd0}},
      '{FUNC_SPARE,           16'h1234, 1'b1, '{1'b0, bat_pkg::STATUS_OK,       5'd0}},
      '{bat_pkg::FUNC_ADD,    16'h0000, 1'b1, '{1'b0, bat_pkg::STATUS_OK,       5'd1}},
      '{bat_pkg::FUNC_ADD,    16'hFFFF, 1'b1, '{1'b0, bat_pkg::STATUS_OK,       5'd2}},
      '{bat_pkg::FUNC_LOOKUP, 16'hFFFF, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd2}},
      '{bat_pkg::FUNC_ADD,    16'hFFFF, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd3}},
      '{bat_pkg::FUNC_ADD,    16'h8000, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h0001, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h7FFF, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'hAAAA, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h5555, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h00FF, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'hFF00, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h1234, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h0F0F, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'hF0F0, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h3C3C, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'hC3C3, 1'b0, NO_RESULT},
      '{bat_pkg::FUNC_ADD,    16'h0000, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd16}},
      '{bat_pkg::FUNC_ADD,    16'hFFFF, 1'b1, '{1'b1, bat_pkg::STATUS_FULL,     5'd16}},
      '{bat_pkg::FUNC_REMOVE, 16'hFFFF, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd15}},
      '{bat_pkg::FUNC_LOOKUP, 16'hFFFF, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd15}},
      '{bat_pkg::FUNC_REMOVE, 16'h0000, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd14}},
      '{FUNC_SPARE,           16'h0000, 1'b1, '{1'b1, bat_pkg::STATUS_OK,       5'd14}}
   };

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [bat_pkg::FUNC_W-1:0]   req_func;
   logic [bat_pkg::ADDR_W-1:0]   req_addr;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_hit;
   logic [bat_pkg::STATUS_W-1:0] rsp_status;
   logic [bat_pkg::COUNT_W-1:0]  rsp_entry_count;

   // Shadow copy of the breakpoint list, kept in the same order as the block's cells.
   logic [bat_pkg::ADDR_W-1:0] bp_shadow [TABLE_DEPTH];
   int                         bp_fill = 0;

   // Responses still owed by the block, oldest first.
   bat_result_type pending_results [$];

   // Small set of addresses reused often, so that hits and duplicates are common.
   logic [bat_pkg::ADDR_W-1:0] addr_pool [8];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int rsp_stall      = 0;
   bit send_busy      = 1'b1;
   bit take_busy      = 1'b1;

   breakpoint_address_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_addr       (req_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one accepted operation to the shadow list and returns the response it owes.
   // The hit flag reflects the list before the operation, whatever the operation is.
   function automatic bat_result_type predict_table_op(input logic [bat_pkg::FUNC_W-1:0] f,
                                                       input logic [bat_pkg::ADDR_W-1:0] a);
      int             first_hit;
      bat_result_type r;
      first_hit = -1;
      // Scan downward so that the lowest matching position is the one that remains.
      for (int k = bp_fill - 1; k >= 0; k--) begin
         if (bp_shadow[k] == a) first_hit = k;
      end
      r.hit    = (first_hit >= 0);
      r.status = bat_pkg::STATUS_OK;
      case (f)
         bat_pkg::FUNC_ADD: begin
            if (bp_fill < TABLE_DEPTH) begin
               bp_shadow[bp_fill] = a;
               bp_fill++;
            end else begin
               r.status = bat_pkg::STATUS_FULL;
            end
         end
         bat_pkg::FUNC_REMOVE: begin
            if (first_hit >= 0) begin
               // Close the gap: every later entry moves down one place, order kept.
               for (int k = first_hit; k < bp_fill - 1; k++) bp_shadow[k] = bp_shadow[k + 1];
               bp_fill--;
            end else begin
               r.status = bat_pkg::STATUS_NOTFOUND;
            end
         end
         default: begin
            // Lookup and the spare code leave the list alone.
         end
      endcase
      r.entry_count = bat_pkg::COUNT_W'(bp_fill);
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      if (mismatch_count < REPORT_LIMIT) $display("tb_top: %s", msg);
      mismatch_count++;
   endfunction

   // Offers one request beat after a random gap and returns at the edge that accepts it.
   // Valid is only lowered when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_beat(input logic [bat_pkg::FUNC_W-1:0] f,
                            input logic [bat_pkg::ADDR_W-1:0] a,
                            input logic typed, input bat_result_type want);
      int             gap;
      bat_result_type predicted;
      gap = send_busy ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_addr  <= a;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = predict_table_op(f, a);
      pending_results.push_back(typed ? want : predicted);
      // Switch now and then between stretches with gaps and stretches without.
      if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
   endtask

   // Holds the request side idle until every owed response has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Response side: checks each accepted beat against the oldest owed response and then
   // draws how long to hold ready low before taking the next one.
   always @(posedge clock) begin
      bat_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_failure("response beat with nothing outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit || rsp_status !== want.status ||
                rsp_entry_count !== want.entry_count) begin
               note_failure($sformatf(
                  "mismatch: want hit=%0d status=%0d count=%0d, got hit=%0d status=%0d count=%0d",
                  want.hit, want.status, want.entry_count,
                  rsp_hit, rsp_status, rsp_entry_count));
            end
         end
         if ($urandom_range(0, 39) == 0) take_busy = !take_busy;
         rsp_stall = take_busy ? $urandom_range(0, 6) : 0;
         rsp_ready <= (rsp_stall == 0);
      end else if (!rsp_ready) begin
         if (rsp_stall <= 1) begin
            rsp_ready <= 1'b1;
            rsp_stall = 0;
         end else begin
            rsp_stall--;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [bat_pkg::FUNC_W-1:0] f;
      logic [bat_pkg::ADDR_W-1:0] a;
      int                         pick;
      bit                         grow;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= bat_pkg::FUNC_LOOKUP;
      req_addr  <= '0;
      addr_pool[0] = 16'h0000;
      addr_pool[1] = 16'hFFFF;
      for (int k = 2; k < 8; k++) addr_pool[k] = bat_pkg::ADDR_W'($urandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         send_beat(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].addr,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      // Let the block go fully idle once before the random traffic starts.
      wait_for_results();

      // Random traffic alternates between a growing and a shrinking bias, so that the
      // list swings between empty and full and both refusals are reached often. Removes
      // and lookups often name an address that is in the list right now.
      grow = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (bp_fill == TABLE_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
         else if (bp_fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick >= 95) f = FUNC_SPARE;
         else if (pick < (grow ? 55 : 15)) f = bat_pkg::FUNC_ADD;
         else if (pick < (grow ? 75 : 70)) f = bat_pkg::FUNC_REMOVE;
         else f = bat_pkg::FUNC_LOOKUP;
         pick = $urandom_range(0, 99);
         if (pick < 40 && bp_fill != 0) a = bp_shadow[$urandom_range(0, bp_fill - 1)];
         else if (pick < 75) a = addr_pool[$urandom_range(0, 7)];
         else a = bat_pkg::ADDR_W'($urandom);
         send_beat(f, a, 1'b0, NO_RESULT);
         if (n % 150 == 149) wait_for_results();
      end

      wait_for_results();
      // Keep the clock running so that a stray extra response beat is still caught.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
